@@ hdl/frm_pkg.sv @@
`default_nettype none
package frm_pkg;

   localparam int WINDOW_DEPTH = 32;
   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int DUR_W = 16;
   localparam int AVG_W = 16;
   localparam int FPS_W = 10;
   localparam int SUM_W = $clog2(WINDOW_DEPTH * 65535 + 1);
   localparam int RATE_NUMERATOR = 1000;
   localparam int RATE_BITS = 10;
   localparam int CNT_W = $clog2(RATE_BITS + 1);
   localparam int RESET_DURATION = 1;
   localparam int AVG_MAX = 65535;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MEAN,
      ST_RATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [RATE_BITS-1:0] dividend;
      logic [AVG_W-1:0]     divisor;
      logic [CNT_W-1:0]     bits;
   } div_cmd_type;

endpackage
`default_nettype wire

@@ hdl/frm_window.sv @@
`default_nettype none
module frm_window (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [frm_pkg::SLOT_W-1:0]   rd_slot,
   input  wire logic                         wr_en,
   input  wire logic [frm_pkg::SLOT_W-1:0]   wr_slot,
   input  wire logic [frm_pkg::DUR_W-1:0]    wr_data,
   output logic      [frm_pkg::DUR_W-1:0]    rd_data
);

   logic [frm_pkg::DUR_W-1:0]        mem [frm_pkg::WINDOW_DEPTH];
   logic [frm_pkg::WINDOW_DEPTH-1:0] valid_ff;
   logic [frm_pkg::WINDOW_DEPTH-1:0] valid_in;
   logic [frm_pkg::DUR_W-1:0]        rd_mem_ff;
   logic                             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_data;
      end
      rd_mem_ff <= mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_slot];
      end
   end

   // entries never written since reset read as one
   assign rd_data = rd_valid_ff ? rd_mem_ff : frm_pkg::DUR_W'(frm_pkg::RESET_DURATION);

endmodule
`default_nettype wire

@@ hdl/frm_divider.sv @@
`default_nettype none
module frm_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire frm_pkg::div_cmd_type          cmd,
   output logic      [frm_pkg::RATE_BITS-1:0] quotient,
   output logic                               done
);

   logic [frm_pkg::AVG_W-1:0]     rem_ff, rem_in;
   logic [frm_pkg::RATE_BITS-1:0] quo_ff, quo_in;
   logic [frm_pkg::AVG_W-1:0]     div_ff, div_in;
   logic [frm_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          done_ff, done_in;
   logic [frm_pkg::AVG_W:0]       trial;
   logic [frm_pkg::AVG_W:0]       diff;
   logic                          fits;

   always_comb begin
      trial = {rem_ff, quo_ff[frm_pkg::RATE_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         rem_in   = '0;
         quo_in   = cmd.dividend;
         div_in   = cmd.divisor;
         count_in = cmd.bits;
      end else if (count_ff != '0) begin
         // one quotient bit per cycle, restoring
         rem_in   = fits ? diff[frm_pkg::AVG_W-1:0] : trial[frm_pkg::AVG_W-1:0];
         quo_in   = {quo_ff[frm_pkg::RATE_BITS-2:0], fits};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == frm_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

@@ hdl/frame_rate_moving_average_unit.sv @@
`default_nettype none
// Moving-average frame-rate meter. Each item carries one frame duration in
// milliseconds; it replaces the oldest of the last 32 durations (all 1 after
// reset), and the result gives the truncated mean of the window, at least 1,
// and 1000 divided by that mean as frames per second. From acceptance
// to result, the block updates the window and running sum, takes the mean by
// a shift and loads the divider, lets the single restoring divider produce
// the rate one bit per cycle and flag done, and then loads the output
// register. The block takes no new item while one is in work. It accepts
// the next item while a finished result waits on rsp_stall; that item's
// result then holds until the waiting one is taken.
module frame_rate_moving_average_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [frm_pkg::DUR_W-1:0]  req_frame_ms,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [frm_pkg::AVG_W-1:0]  rsp_average_ms,
   output logic      [frm_pkg::FPS_W-1:0]  rsp_frames_per_second
);

   frm_pkg::state_type              state_ff, state_in;
   logic [frm_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic [frm_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [frm_pkg::SUM_W-1:0]       mean;
   logic [frm_pkg::DUR_W-1:0]       dur_ff;
   logic [frm_pkg::AVG_W-1:0]       avg_ff;
   logic [frm_pkg::AVG_W-1:0]       avg_clamped;
   logic [frm_pkg::FPS_W-1:0]       fps_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [frm_pkg::AVG_W-1:0]       rsp_avg_ff;
   logic [frm_pkg::FPS_W-1:0]       rsp_fps_ff;
   logic [frm_pkg::DUR_W-1:0]       old_dur;
   logic [frm_pkg::RATE_BITS-1:0]   quotient;
   logic                            div_done;
   frm_pkg::div_cmd_type            div_cmd;
   logic                            req_accept;
   logic                            win_wr_en;
   logic                            out_load;
   logic                            out_free;

   frm_window u_window (
      .clock   (clock),
      .reset   (reset),
      .rd_slot (slot_ff),
      .wr_en   (win_wr_en),
      .wr_slot (slot_ff),
      .wr_data (dur_ff),
      .rd_data (old_dur)
   );

   frm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .quotient (quotient),
      .done     (div_done)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // window depth is a power of two, so the mean is a shift
   assign mean = sum_ff / frm_pkg::SUM_W'(frm_pkg::WINDOW_DEPTH);

   always_comb begin
      if (mean == '0) begin
         avg_clamped = frm_pkg::AVG_W'(1);
      end else if (mean > frm_pkg::SUM_W'(frm_pkg::AVG_MAX)) begin
         avg_clamped = frm_pkg::AVG_W'(frm_pkg::AVG_MAX);
      end else begin
         avg_clamped = mean[frm_pkg::AVG_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         frm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = frm_pkg::ST_UPDATE;
            end
         end
         frm_pkg::ST_UPDATE: state_in = frm_pkg::ST_MEAN;
         frm_pkg::ST_MEAN: state_in = frm_pkg::ST_RATE;
         frm_pkg::ST_RATE: begin
            if (div_done) begin
               state_in = frm_pkg::ST_DONE;
            end
         end
         frm_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = frm_pkg::ST_IDLE;
            end
         end
         default: state_in = frm_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall        = 1'b1;
      win_wr_en        = 1'b0;
      out_load         = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = frm_pkg::RATE_BITS'(frm_pkg::RATE_NUMERATOR);
      div_cmd.divisor  = avg_clamped;
      div_cmd.bits     = frm_pkg::CNT_W'(frm_pkg::RATE_BITS);
      case (state_ff)
         frm_pkg::ST_IDLE: req_stall = 1'b0;
         frm_pkg::ST_UPDATE: win_wr_en = 1'b1;
         frm_pkg::ST_MEAN: div_cmd.start = 1'b1;
         frm_pkg::ST_RATE: ;
         frm_pkg::ST_DONE: out_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      sum_in = sum_ff - frm_pkg::SUM_W'(old_dur) + frm_pkg::SUM_W'(dur_ff);
      if (slot_ff == frm_pkg::SLOT_W'(frm_pkg::WINDOW_DEPTH - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frm_pkg::ST_IDLE;
         slot_ff      <= '0;
         sum_ff       <= frm_pkg::SUM_W'(frm_pkg::WINDOW_DEPTH * frm_pkg::RESET_DURATION);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (win_wr_en) begin
            slot_ff <= slot_in;
            sum_ff  <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         dur_ff <= req_frame_ms;
      end
      if (state_ff == frm_pkg::ST_MEAN) begin
         avg_ff <= avg_clamped;
      end
      if (state_ff == frm_pkg::ST_RATE && div_done) begin
         fps_ff <= quotient[frm_pkg::FPS_W-1:0];
      end
      if (out_load) begin
         rsp_avg_ff <= avg_ff;
         rsp_fps_ff <= fps_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_average_ms        = rsp_avg_ff;
   assign rsp_frames_per_second = rsp_fps_ff;

endmodule
`default_nettype wire

@@ test/frame_rate_moving_average_unit_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module frame_rate_moving_average_unit_tb;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_WAIT  = 60;
   localparam int RANDOM_ITEMS = 900;

   typedef struct {
      logic [frm_pkg::DUR_W-1:0] ms;
      bit                        steady;
      bit                        wait_drain;
   } frame_item_type;

   typedef struct {
      logic [frm_pkg::AVG_W-1:0] average_ms;
      logic [frm_pkg::FPS_W-1:0] fps;
   } frame_rate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [frm_pkg::DUR_W-1:0] req_frame_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [frm_pkg::AVG_W-1:0] rsp_average_ms;
   logic [frm_pkg::FPS_W-1:0] rsp_frames_per_second;

   frame_item_type frames_pending[$];
   frame_rate_type rates_expected[$];

   // Shadow of the block's window, next slot and running sum.
   logic [frm_pkg::DUR_W-1:0] shadow_window[frm_pkg::WINDOW_DEPTH];
   int unsigned               shadow_slot;
   int unsigned               shadow_sum;

   logic req_taken = 1'b0;
   bit   steady_phase = 1'b0;
   int   error_count = 0;
   int   frames_sent = 0;
   int   rates_checked = 0;
   int   clamped_means = 0;
   int   zero_rates = 0;
   int   saturated_means = 0;
   int   cycle_count = 0;

   frame_rate_moving_average_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_frame_ms         (req_frame_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_average_ms       (rsp_average_ms),
      .rsp_frames_per_second(rsp_frames_per_second)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic frame_rate_type predict_frame_rate(
      input logic [frm_pkg::DUR_W-1:0] ms);
      frame_rate_type r;
      int unsigned mean;
      shadow_sum = shadow_sum - shadow_window[shadow_slot] + ms;
      shadow_window[shadow_slot] = ms;
      shadow_slot = (shadow_slot == frm_pkg::WINDOW_DEPTH - 1) ? 0 : shadow_slot + 1;
      mean = shadow_sum / frm_pkg::WINDOW_DEPTH;
      if (mean < 1) begin
         mean = 1;
         clamped_means++;
      end
      if (mean > frm_pkg::AVG_MAX) begin
         mean = frm_pkg::AVG_MAX;
      end
      if (mean == frm_pkg::AVG_MAX) begin
         saturated_means++;
      end
      r.average_ms = mean[frm_pkg::AVG_W-1:0];
      r.fps = frm_pkg::FPS_W'(frm_pkg::RATE_NUMERATOR / mean);
      if (r.fps == 0) begin
         zero_rates++;
      end
      return r;
   endfunction

   function automatic void queue_frame(input int ms, input bit steady, input bit wait_drain);
      frame_item_type it;
      it.ms = (ms > 65535) ? 16'hFFFF : ((ms < 0) ? 16'h0000 : ms[frm_pkg::DUR_W-1:0]);
      it.steady = steady;
      it.wait_drain = wait_drain;
      frames_pending.push_back(it);
   endfunction

   // Predict on every accepted item, check every accepted result.
   always @(posedge clock) begin
      frame_rate_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         rates_expected.push_back(predict_frame_rate(req_frame_ms));
         frames_sent++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rates_expected.size() == 0) begin
            $display("%0t: unexpected result average_ms=%0d fps=%0d", $time,
                     rsp_average_ms, rsp_frames_per_second);
            error_count++;
         end else begin
            want = rates_expected.pop_front();
            rates_checked++;
            if (rsp_average_ms !== want.average_ms) begin
               $display("%0t: average_ms mismatch expected %0d actual %0d", $time,
                        want.average_ms, rsp_average_ms);
               error_count++;
            end
            if (rsp_frames_per_second !== want.fps) begin
               $display("%0t: frames_per_second mismatch expected %0d actual %0d", $time,
                        want.fps, rsp_frames_per_second);
               error_count++;
            end
         end
      end
   end

   // Driver: hold a presented item until taken, then load the next or idle.
   always @(negedge clock) begin
      bit idle_now;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         idle_now = 1'b0;
         if (frames_pending.size() == 0) begin
            idle_now = 1'b1;
         end else if (frames_pending[0].wait_drain && rates_expected.size() != 0) begin
            idle_now = 1'b1;
         end else if (!frames_pending[0].steady && $urandom_range(0, 99) < 6) begin
            idle_now = 1'b1;
         end
         if (idle_now) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_frame_ms <= frames_pending[0].ms;
            steady_phase <= frames_pending[0].steady;
            void'(frames_pending.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && !steady_phase && ($urandom_range(0, 99) < 6);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, rates_expected.size());
         $display("frame_rate_moving_average_unit test failed");
         $finish;
      end
   end

   initial begin
      int rand_count;
      int mode;
      int run_len;
      int base;
      int jitter;
      int ms;
      bit steady;
      bit wait_drain;

      for (int i = 0; i < frm_pkg::WINDOW_DEPTH; i++) begin
         shadow_window[i] = frm_pkg::DUR_W'(frm_pkg::RESET_DURATION);
      end
      shadow_slot = 0;
      shadow_sum = frm_pkg::WINDOW_DEPTH * frm_pkg::RESET_DURATION;

      // Directed: first zero drops the mean below one, then the field extremes,
      // a mean above 1000 for a zero rate, and patterns for every input bit.
      queue_frame(0, 1'b0, 1'b0);
      queue_frame(0, 1'b0, 1'b0);
      queue_frame(65535, 1'b0, 1'b0);
      queue_frame(65535, 1'b0, 1'b0);
      queue_frame(1, 1'b0, 1'b0);
      queue_frame(1000, 1'b0, 1'b0);
      queue_frame(999, 1'b0, 1'b0);
      queue_frame(1001, 1'b0, 1'b0);
      queue_frame(2, 1'b0, 1'b0);
      queue_frame(32768, 1'b0, 1'b0);
      queue_frame(16'h5555, 1'b0, 1'b0);
      queue_frame(16'hAAAA, 1'b0, 1'b0);
      queue_frame(16, 1'b0, 1'b0);
      queue_frame(17, 1'b0, 1'b0);
      queue_frame(33, 1'b0, 1'b0);
      queue_frame(500, 1'b0, 1'b0);
      queue_frame(0, 1'b0, 1'b0);
      queue_frame(65535, 1'b0, 1'b0);

      // Random: mostly runs near a steady frame time so the window fills with
      // one rate, mixed with noise, all-zero and all-max windows.
      rand_count = 0;
      while (rand_count < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         case (mode)
            6: run_len = $urandom_range(1, 10);
            7, 8: run_len = $urandom_range(frm_pkg::WINDOW_DEPTH, frm_pkg::WINDOW_DEPTH + 8);
            default: run_len = $urandom_range(8, 48);
         endcase
         case ($urandom_range(0, 2))
            0: base = $urandom_range(0, 100);
            1: base = $urandom_range(10, 40);
            default: base = $urandom_range(0, 65535);
         endcase
         jitter = $urandom_range(0, 3);
         for (int k = 0; k < run_len && rand_count < RANDOM_ITEMS; k++) begin
            case (mode)
               6: ms = $urandom_range(0, 65535);
               7: ms = 0;
               8: ms = 65535 - $urandom_range(0, 1);
               9: ms = $urandom_range(0, 40);
               default: ms = base + $urandom_range(0, jitter) - jitter / 2;
            endcase
            steady = (rand_count >= 300 && rand_count < 460);
            wait_drain = (rand_count == 0 || rand_count == 600);
            queue_frame(ms, steady, wait_drain);
            rand_count++;
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (frames_pending.size() != 0 || req_valid) @(posedge clock);
      while (rates_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("Sent %0d frame times, checked %0d results in %0d cycles.", frames_sent,
               rates_checked, cycle_count);
      $display("Means clamped to one: %0d, zero rates: %0d, saturated means: %0d.",
               clamped_means, zero_rates, saturated_means);
      if (error_count == 0 && rates_expected.size() == 0) begin
         $display("frame_rate_moving_average_unit test passed");
      end else begin
         $display("frame_rate_moving_average_unit test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ frame_rate_moving_average_unit.f @@
hdl/frm_pkg.sv
hdl/frm_window.sv
hdl/frm_divider.sv
hdl/frame_rate_moving_average_unit.sv
test/frame_rate_moving_average_unit_tb.sv
